// ===== sv/plclut_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the piecewise-linear color table block.
// Used by the controller, the datapath and the top level; depends on nothing.
package plclut_pkg;

  localparam int unsigned MAX_POINTS = 32;
  localparam int unsigned LEVEL_W = 17;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned NUM_CHAN = 4;
  localparam int unsigned COLOR_W = CHAN_W * NUM_CHAN;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned RES_W = 16;
  localparam int unsigned PROD_W = 25;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [LEVEL_W-1:0] ONE_LEVEL = 17'h10000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic lookup;
    logic scan_step;
    logic mul;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ===== sv/piecewise_linear_color_lut_top.sv =====
`timescale 1ns / 1ps
// Top level of the piecewise-linear RGBA color table block.
// Depends on plclut_pkg, plclut_ctrl, plclut_dp and plclut_ram.
//
// A transaction is taken at a rising edge where start_i is high and busy_o is low;
// operation_i selects clear, append or lookup, and code 3 is ignored.
// Clear and append finish in the accepting cycle, keep busy_o low and give no result.
// Appending to a full store drops the point and sets the overflow flag until a clear.
// A lookup raises busy_o, scans the stored points one per cycle, then forms the
// channel products and runs the four-lane restoring divider.
// The scan stops at the first point whose level reaches the entry intensity, or at the
// last stored point. done_o is high for one cycle with the result; busy_o is low in
// that cycle, so the next transaction may be taken in it, and no transaction is taken
// while a lookup is still running.
// The scan over the point store's single read port and the divider bound the lookup time.
// The result is not held: the receiver must take it in the strobe cycle and cannot stall.
// Reset clears the point count and overflow flag and returns the controller to idle;
// the point store itself is not cleared.
module piecewise_linear_color_lut_top #(
  parameter int unsigned MaxPoints = plclut_pkg::MAX_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          operation_i,
  input  logic [plclut_pkg::LEVEL_W-1:0]      point_level_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_red_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_green_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_blue_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_alpha_i,
  input  logic [plclut_pkg::IDX_W-1:0]        entry_index_i,
  output logic                                done_o,
  output logic [plclut_pkg::IDX_W-1:0]        out_index_o,
  output logic [plclut_pkg::RES_W-1:0]        out_red_o,
  output logic [plclut_pkg::RES_W-1:0]        out_green_o,
  output logic [plclut_pkg::RES_W-1:0]        out_blue_o,
  output logic [plclut_pkg::RES_W-1:0]        out_alpha_o,
  output logic                                overflow_o
);

  plclut_pkg::cmd_t    cmd;
  plclut_pkg::status_t status;

  plclut_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(operation_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .done_o     (done_o)
  );

  plclut_dp #(
    .MaxPoints(MaxPoints)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .point_level_i(point_level_i),
    .point_red_i  (point_red_i),
    .point_green_i(point_green_i),
    .point_blue_i (point_blue_i),
    .point_alpha_i(point_alpha_i),
    .entry_index_i(entry_index_i),
    .out_index_o  (out_index_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .overflow_o   (overflow_o)
  );

endmodule

// ===== sv/plclut_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the control point store.
module plclut_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/plclut_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: decodes transactions and sequences scan, multiply and divide.
// Depends on plclut_pkg for operation codes and the command and status structs.
module plclut_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            operation_i,
  input  plclut_pkg::status_t   status_i,
  output plclut_pkg::cmd_t      cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [plclut_pkg::DIV_CNT_W-1:0] step_q, step_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        state_d = ST_IDLE;
        if (accept) begin
          case (plclut_pkg::op_e'(operation_i))
            plclut_pkg::OP_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            plclut_pkg::OP_APPEND: begin
              cmd_o.append = 1'b1;
            end
            plclut_pkg::OP_LOOKUP: begin
              cmd_o.lookup = 1'b1;
              state_d      = ST_SCAN;
              busy_d       = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        step_d    = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + plclut_pkg::DIV_CNT_W'(1);
        if (step_q == plclut_pkg::DIV_CNT_W'(plclut_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DONE;
          busy_d  = 1'b0;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result strobe raised while still busy");

  a_done_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_DIV))
    else $error("result strobe without a finished division");

  a_lookup_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == plclut_pkg::OP_LOOKUP) |=> busy_q)
    else $error("lookup transaction did not raise busy");

endmodule

// ===== sv/plclut_dp.sv =====
`timescale 1ns / 1ps
// Datapath: point store, sequential scan, per-channel multiply and a four-lane divider.
// Depends on plclut_pkg and plclut_ram.
module plclut_dp #(
  parameter int unsigned MaxPoints = plclut_pkg::MAX_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  plclut_pkg::cmd_t                    cmd_i,
  output plclut_pkg::status_t                 status_o,
  input  logic [plclut_pkg::LEVEL_W-1:0]      point_level_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_red_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_green_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_blue_i,
  input  logic [plclut_pkg::CHAN_W-1:0]       point_alpha_i,
  input  logic [plclut_pkg::IDX_W-1:0]        entry_index_i,
  output logic [plclut_pkg::IDX_W-1:0]        out_index_o,
  output logic [plclut_pkg::RES_W-1:0]        out_red_o,
  output logic [plclut_pkg::RES_W-1:0]        out_green_o,
  output logic [plclut_pkg::RES_W-1:0]        out_blue_o,
  output logic [plclut_pkg::RES_W-1:0]        out_alpha_o,
  output logic                                overflow_o
);

  localparam int unsigned PtrW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned LvW = plclut_pkg::LEVEL_W;
  localparam int unsigned ChW = plclut_pkg::CHAN_W;
  localparam int unsigned ColW = plclut_pkg::COLOR_W;
  localparam int unsigned ResW = plclut_pkg::RES_W;
  localparam int unsigned PrW = plclut_pkg::PROD_W;
  localparam int unsigned NCh = plclut_pkg::NUM_CHAN;
  localparam int unsigned EntW = LvW + ColW;

  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic [PtrW-1:0] ptr_q, ptr_d;

  logic [plclut_pkg::IDX_W-1:0] idx_q;
  logic [LvW-1:0]  cur_q, cur_d;
  logic [LvW-1:0]  prev_lvl_q, next_lvl_q;
  logic [ColW-1:0] prev_col_q, next_col_q;
  logic [LvW-1:0]  div_q;
  logic            blend_q;
  logic [LvW-1:0]  rem_q [NCh];
  logic [ResW-1:0] quo_q [NCh];

  logic            full;
  logic            ram_we;
  logic [EntW-1:0] ram_wdata;
  logic [EntW-1:0] ram_rdata;
  logic [LvW-1:0]  rd_level;
  logic [ColW-1:0] rd_color;
  logic            count_zero, scan_hit, scan_last;

  logic [LvW-1:0]  diff;
  logic [LvW-1:0]  span;
  logic            blend;
  logic [PrW-1:0]  prod [NCh];
  logic [LvW-1:0]  rem_d [NCh];
  logic [ResW-1:0] quo_d [NCh];

  assign full      = count_q == CntW'(MaxPoints);
  assign ram_we    = cmd_i.append && !full;
  assign ram_wdata = {point_level_i, point_alpha_i, point_blue_i, point_green_i, point_red_i};
  assign rd_level  = ram_rdata[EntW-1:ColW];
  assign rd_color  = ram_rdata[ColW-1:0];

  assign count_zero = count_q == '0;
  assign scan_hit   = rd_level >= cur_q;
  assign scan_last  = (CntW'(ptr_q) + CntW'(1)) == count_q;
  assign status_o.scan_done = count_zero || scan_hit || scan_last;

  assign cur_d = LvW'({entry_index_i, 8'h00}) + LvW'(entry_index_i)
               + LvW'(entry_index_i == 8'hFF);

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    ptr_d     = ptr_q;
    if (cmd_i.clear) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
    if (cmd_i.append) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.lookup) begin
      ptr_d = '0;
    end else if (cmd_i.scan_step && !status_o.scan_done) begin
      ptr_d = ptr_q + PtrW'(1);
    end
  end

  plclut_ram #(
    .Width(EntW),
    .Depth(MaxPoints)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[PtrW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ptr_d),
    .rdata_o(ram_rdata)
  );

  assign diff  = cur_q - prev_lvl_q;
  assign span  = next_lvl_q - prev_lvl_q;
  assign blend = (next_lvl_q > prev_lvl_q) && (cur_q >= prev_lvl_q) && (cur_q <= next_lvl_q);

  always_comb begin
    logic [LvW:0] trial;
    trial = '0;
    for (int ch = 0; ch < NCh; ch++) begin
      prod[ch] = PrW'(PrW'(prev_col_q[ch*ChW +: ChW]) * PrW'(span - diff))
               + PrW'(PrW'(next_col_q[ch*ChW +: ChW]) * PrW'(diff));
      trial = {rem_q[ch], quo_q[ch][ResW-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d[ch] = LvW'(trial - {1'b0, div_q});
        quo_d[ch] = {quo_q[ch][ResW-2:0], 1'b1};
      end else begin
        rem_d[ch] = trial[LvW-1:0];
        quo_d[ch] = {quo_q[ch][ResW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      ptr_q     <= '0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      ptr_q     <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      idx_q      <= entry_index_i;
      cur_q      <= cur_d;
      prev_lvl_q <= '0;
      prev_col_q <= '0;
    end
    if (cmd_i.scan_step) begin
      if (count_zero) begin
        next_lvl_q <= plclut_pkg::ONE_LEVEL;
        next_col_q <= '0;
      end else if (scan_hit) begin
        next_lvl_q <= rd_level;
        next_col_q <= rd_color;
      end else begin
        prev_lvl_q <= rd_level;
        prev_col_q <= rd_color;
        if (scan_last) begin
          next_lvl_q <= plclut_pkg::ONE_LEVEL;
          next_col_q <= '0;
        end
      end
    end
    if (cmd_i.mul) begin
      blend_q <= blend;
      div_q   <= blend ? span : LvW'(1);
      for (int ch = 0; ch < NCh; ch++) begin
        rem_q[ch] <= blend ? prod[ch][PrW-1:ChW] : '0;
        quo_q[ch] <= blend ? {prod[ch][ChW-1:0], 8'h00} : '0;
      end
    end
    if (cmd_i.div_step) begin
      for (int ch = 0; ch < NCh; ch++) begin
        rem_q[ch] <= rem_d[ch];
        quo_q[ch] <= quo_d[ch];
      end
    end
  end

  assign out_index_o = idx_q;
  assign out_red_o   = blend_q ? quo_q[0] : {prev_col_q[0*ChW +: ChW], 8'h00};
  assign out_green_o = blend_q ? quo_q[1] : {prev_col_q[1*ChW +: ChW], 8'h00};
  assign out_blue_o  = blend_q ? quo_q[2] : {prev_col_q[2*ChW +: ChW], 8'h00};
  assign out_alpha_o = blend_q ? quo_q[3] : {prev_col_q[3*ChW +: ChW], 8'h00};
  assign overflow_o  = dropped_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints))
    else $error("point count exceeds the store depth");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && !count_zero) |-> (CntW'(ptr_q) < count_q))
    else $error("scan pointer passed the last stored point");

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |=> (div_q != '0))
    else $error("divider loaded with a zero divisor");

endmodule
